FILE: hw/rtl/sample_mean_variance_min_max_defines.svh
// ----------------------------------------------------------------------------
// Sample statistics assertion macros
// Shared assertion shorthands for the sample statistics block checkers.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MEAN_VARIANCE_MIN_MAX_DEFINES_SVH
`define SAMPLE_MEAN_VARIANCE_MIN_MAX_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define SMV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/smvmm_pkg.sv
// ----------------------------------------------------------------------------
// Sample statistics package
// Widths, depth and control types shared by the sample statistics block.
// ----------------------------------------------------------------------------
package smvmm_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_W    = 32;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_W + ADDR_W;
    localparam int VAR_W       = 64;
    localparam int ITER_W      = $clog2(VAR_W + 1);

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // sample transfer this cycle
        logic div_start;  // launch divider
        logic div_var;    // divider works on variance sum
        logic mean_load;  // capture mean, prepare variance pass
        logic pass_run;   // stream stored samples
        logic load_out;   // capture result, clear run
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic pass_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: hw/rtl/smvmm_if.sv
// ----------------------------------------------------------------------------
// Sample statistics channels
// Valid/ready channels for incoming samples and outgoing results.
// ----------------------------------------------------------------------------
interface smvmm_sample_if;
    logic                              valid;
    logic                              ready;
    logic [smvmm_pkg::SAMPLE_W-1:0]    sample;
    logic                              last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface smvmm_result_if;
    logic                              valid;
    logic                              ready;
    logic [smvmm_pkg::SAMPLE_W-1:0]    mean_value;
    logic [smvmm_pkg::VAR_W-1:0]       variance_value;
    logic [smvmm_pkg::SAMPLE_W-1:0]    smallest;
    logic [smvmm_pkg::SAMPLE_W-1:0]    largest;
    logic [smvmm_pkg::CNT_W-1:0]       sample_count;
    logic                              overflowed;

    modport source (output valid, mean_value, variance_value, smallest, largest,
                    sample_count, overflowed, input ready);
    modport sink   (input valid, mean_value, variance_value, smallest, largest,
                    sample_count, overflowed, output ready);
endinterface

FILE: hw/rtl/smvmm_div.sv
// ----------------------------------------------------------------------------
// Sample statistics divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend by count.
// ----------------------------------------------------------------------------
module smvmm_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [smvmm_pkg::VAR_W-1:0]    dividend,
    input  logic [smvmm_pkg::CNT_W-1:0]    divisor,
    output logic                           done,
    output logic [smvmm_pkg::VAR_W-1:0]    quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [smvmm_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [smvmm_pkg::VAR_W-1:0]     quo_reg, quo_next;
    logic [smvmm_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [smvmm_pkg::CNT_W-1:0]     div_reg, div_next;
    logic [smvmm_pkg::CNT_W:0]       trial;

    // Shift in next dividend bit, subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[smvmm_pkg::VAR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = smvmm_pkg::ITER_W'(smvmm_pkg::VAR_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = smvmm_pkg::CNT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[smvmm_pkg::VAR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[smvmm_pkg::CNT_W-1:0];
                quo_next = {quo_reg[smvmm_pkg::VAR_W-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == smvmm_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/smvmm_datapath.sv
// ----------------------------------------------------------------------------
// Sample statistics datapath
// Sample memory, running sum/min/max, variance pass pipeline, result register.
// ----------------------------------------------------------------------------
module smvmm_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  smvmm_pkg::ctrl_cmd_t              cmd,
    output smvmm_pkg::ctrl_sts_t              sts,
    input  logic [smvmm_pkg::SAMPLE_W-1:0]    in_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [smvmm_pkg::SAMPLE_W-1:0]    out_mean,
    output logic [smvmm_pkg::VAR_W-1:0]       out_var,
    output logic [smvmm_pkg::SAMPLE_W-1:0]    out_min,
    output logic [smvmm_pkg::SAMPLE_W-1:0]    out_max,
    output logic [smvmm_pkg::CNT_W-1:0]       out_count,
    output logic                              out_drop
);

    logic [smvmm_pkg::SAMPLE_W-1:0]  mem [smvmm_pkg::MAX_SAMPLES];

    logic [smvmm_pkg::CNT_W-1:0]     cnt_reg;
    logic [smvmm_pkg::SUM_W-1:0]     sum_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  min_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  max_reg;
    logic                            drop_reg;
    logic                            full;

    logic [smvmm_pkg::SAMPLE_W-1:0]  mean_reg;
    logic [smvmm_pkg::CNT_W-1:0]     rd_idx_reg;
    logic                            issue;
    logic [smvmm_pkg::SAMPLE_W-1:0]  rdata_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  diff_reg;
    logic [smvmm_pkg::VAR_W-1:0]     prod_reg;
    logic [smvmm_pkg::VAR_W-1:0]     acc_reg;
    logic                            v1_reg, v2_reg, v3_reg;

    logic                            out_valid_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  out_mean_reg;
    logic [smvmm_pkg::VAR_W-1:0]     out_var_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  out_min_reg;
    logic [smvmm_pkg::SAMPLE_W-1:0]  out_max_reg;
    logic [smvmm_pkg::CNT_W-1:0]     out_count_reg;
    logic                            out_drop_reg;

    logic [smvmm_pkg::VAR_W-1:0]     div_dividend;
    logic                            div_done;
    logic [smvmm_pkg::VAR_W-1:0]     div_quo;

    assign full  = (cnt_reg == smvmm_pkg::CNT_W'(smvmm_pkg::MAX_SAMPLES));
    assign issue = cmd.pass_run && (rd_idx_reg != cnt_reg);

    // Store accepted samples while room remains
    always_ff @(posedge clk)
    begin
        if (cmd.take && !full)
            mem[cnt_reg[smvmm_pkg::ADDR_W-1:0]] <= in_sample;
        if (issue)
            rdata_reg <= mem[rd_idx_reg[smvmm_pkg::ADDR_W-1:0]];
    end

    // Running statistics; clear once the result is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (full)
                drop_reg <= 1'b1;
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + smvmm_pkg::SUM_W'(in_sample);
                if (in_sample < min_reg)
                    min_reg <= in_sample;
                if (in_sample > max_reg)
                    max_reg <= in_sample;
            end
        end
    end

    // Variance pass control: read index and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else if (cmd.mean_load)
        begin
            rd_idx_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            if (issue)
                rd_idx_reg <= rd_idx_reg + 1'b1;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Distance from mean, square, accumulate modulo 2^64
    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            mean_reg <= div_quo[smvmm_pkg::SAMPLE_W-1:0];
            acc_reg  <= '0;
        end
        else if (v3_reg)
            acc_reg <= acc_reg + prod_reg;
        if (v1_reg)
            diff_reg <= (rdata_reg >= mean_reg) ? rdata_reg - mean_reg
                                                : mean_reg - rdata_reg;
        if (v2_reg)
            prod_reg <= smvmm_pkg::VAR_W'(diff_reg) * smvmm_pkg::VAR_W'(diff_reg);
    end

    assign div_dividend = cmd.div_var ? acc_reg : smvmm_pkg::VAR_W'(sum_reg);

    smvmm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result register: hold until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mean_reg  <= mean_reg;
            out_var_reg   <= div_quo;
            out_min_reg   <= min_reg;
            out_max_reg   <= max_reg;
            out_count_reg <= cnt_reg;
            out_drop_reg  <= drop_reg;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.pass_done = (rd_idx_reg == cnt_reg) && !v1_reg && !v2_reg && !v3_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_mean  = out_mean_reg;
    assign out_var   = out_var_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;
    assign out_count = out_count_reg;
    assign out_drop  = out_drop_reg;

endmodule

FILE: hw/rtl/smvmm_ctrl.sv
// ----------------------------------------------------------------------------
// Sample statistics controller
// Sequences sample loading, mean division, variance pass and result capture.
// ----------------------------------------------------------------------------
module smvmm_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    output smvmm_pkg::ctrl_cmd_t   cmd,
    input  smvmm_pkg::ctrl_sts_t   sts
);

    typedef enum logic [6:0] {
        ST_LOAD   = 7'b0000001,
        ST_MSTART = 7'b0000010,
        ST_MWAIT  = 7'b0000100,
        ST_PASS   = 7'b0001000,
        ST_VSTART = 7'b0010000,
        ST_VWAIT  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && in_last)
                    state_next = ST_MSTART;
            end
            ST_MSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    state_next    = ST_PASS;
                end
            end
            ST_PASS:
            begin
                cmd.pass_run = 1'b1;
                if (sts.pass_done)
                    state_next = ST_VSTART;
            end
            ST_VSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_var   = 1'b1;
                state_next    = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                if (sts.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hw/rtl/sample_mean_variance_min_max.sv
// ----------------------------------------------------------------------------
// Sample mean, variance, minimum and maximum
// Collects a run of samples and reports truncated statistics at its end.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  samples   | in  | sample[31:0], last_sample
//  results   | out | mean_value, variance_value, smallest, largest,
//            |     | sample_count, overflowed
//
//  Samples transfer one per cycle while a run loads.
//  After the last sample: mean divide, variance pass over N stored samples
//  (one memory read port), then variance divide.
//  A finished result waits in the output register; the next run loads meanwhile.
//  Reset clears run state; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
module sample_mean_variance_min_max
(
    input  logic           clk,
    input  logic           rst_n,
    smvmm_sample_if.sink   samples,
    smvmm_result_if.source results
);

    smvmm_pkg::ctrl_cmd_t cmd;
    smvmm_pkg::ctrl_sts_t sts;

    smvmm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_last  (samples.last_sample),
        .in_ready (samples.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    smvmm_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_sample (samples.sample),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_mean  (results.mean_value),
        .out_var   (results.variance_value),
        .out_min   (results.smallest),
        .out_max   (results.largest),
        .out_count (results.sample_count),
        .out_drop  (results.overflowed)
    );

endmodule

FILE: hw/rtl/smvmm_checker.sv
// ----------------------------------------------------------------------------
// Sample statistics port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_mean_variance_min_max_defines.svh"

module smvmm_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [smvmm_pkg::SAMPLE_W-1:0]    mean_value,
    input  logic [smvmm_pkg::SAMPLE_W-1:0]    smallest,
    input  logic [smvmm_pkg::SAMPLE_W-1:0]    largest,
    input  logic [smvmm_pkg::CNT_W-1:0]       sample_count
);

    // Held result stays offered
    `SMV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // A result always covers at least one kept sample, never above depth
    `SMV_ASSERT_IMPL(a_count_range, out_valid, (sample_count != '0) && (sample_count <= smvmm_pkg::CNT_W'(smvmm_pkg::MAX_SAMPLES)))
    // Minimum never above maximum
    `SMV_ASSERT_IMPL(a_min_max, out_valid, smallest <= largest)
    // Mean lies between minimum and maximum
    `SMV_ASSERT_IMPL(a_mean_range, out_valid, (mean_value >= smallest) && (mean_value <= largest))

endmodule

bind sample_mean_variance_min_max smvmm_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .mean_value   (results.mean_value),
    .smallest     (results.smallest),
    .largest      (results.largest),
    .sample_count (results.sample_count)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample statistics testbench
// Streams runs of samples into the block and checks each run's mean,
// variance, minimum, maximum, count and drop flag against a local model.
// ----------------------------------------------------------------------------
module testbench;

    // Sample value patterns for queued runs
    localparam int MODE_RANDOM  = 0;
    localparam int MODE_FIXED   = 1;
    localparam int MODE_SMALL   = 2;
    localparam int MODE_EXTREME = 3;

    typedef struct packed {
        logic [smvmm_pkg::SAMPLE_W-1:0] value;
        logic                           last;
    } sample_item_t;

    typedef struct packed {
        logic [smvmm_pkg::SAMPLE_W-1:0] mean_value;
        logic [smvmm_pkg::VAR_W-1:0]    variance_value;
        logic [smvmm_pkg::SAMPLE_W-1:0] smallest;
        logic [smvmm_pkg::SAMPLE_W-1:0] largest;
        logic [smvmm_pkg::CNT_W-1:0]    sample_count;
        logic                           overflowed;
    } stats_t;

    logic clk;
    logic rst_n;

    smvmm_sample_if samples ();
    smvmm_result_if results ();

    sample_mean_variance_min_max i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .results (results.source)
    );

    sample_item_t  pending_samples[$];
    stats_t        expected_stats[$];
    int            send_idle_pct;
    int            recv_stall_pct;
    int            error_count;
    int            run_count;
    int            sample_total;
    int            drop_runs;

    // Run state of the local model
    logic [smvmm_pkg::SAMPLE_W-1:0] run_store[smvmm_pkg::MAX_SAMPLES];
    int                             run_kept;
    logic [smvmm_pkg::SUM_W-1:0]    run_sum;
    logic [smvmm_pkg::SAMPLE_W-1:0] run_min;
    logic [smvmm_pkg::SAMPLE_W-1:0] run_max;
    logic                           run_dropped;

    task automatic clear_run_stats();
        run_kept    = 0;
        run_sum     = '0;
        run_min     = '1;
        run_max     = '0;
        run_dropped = 1'b0;
    endtask

    // Fold one transferred sample into the run, predict stats on the last one
    task automatic absorb_sample(input sample_item_t s);
        stats_t      r;
        logic [63:0] mean;
        logic [63:0] acc;
        logic [63:0] d;
        if (run_kept < smvmm_pkg::MAX_SAMPLES)
        begin
            run_store[run_kept] = s.value;
            run_kept++;
            run_sum += smvmm_pkg::SUM_W'(s.value);
            if (s.value < run_min) run_min = s.value;
            if (s.value > run_max) run_max = s.value;
        end
        else
        begin
            run_dropped = 1'b1;
        end
        if (s.last)
        begin
            mean = 64'(run_sum) / 64'(run_kept);
            acc  = '0;
            for (int i = 0; i < run_kept; i++)
            begin
                d = 64'(run_store[i]) - mean;
                acc += d * d;
            end
            r.mean_value     = mean[smvmm_pkg::SAMPLE_W-1:0];
            r.variance_value = acc / 64'(run_kept);
            r.smallest       = run_min;
            r.largest        = run_max;
            r.sample_count   = smvmm_pkg::CNT_W'(run_kept);
            r.overflowed     = run_dropped;
            expected_stats.push_back(r);
            run_count++;
            if (run_dropped) drop_runs++;
            clear_run_stats();
        end
    endtask

    task automatic queue_run(input int n, input int mode, input logic [31:0] fixed);
        sample_item_t s;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                MODE_RANDOM: s.value = $urandom;
                MODE_FIXED:  s.value = fixed;
                MODE_SMALL:  s.value = $urandom_range(1000, 0);
                default:
                begin
                    if ($urandom_range(1, 0) != 0)
                        s.value = 32'hFFFF_FFFF - $urandom_range(15, 0);
                    else
                        s.value = 32'($urandom_range(15, 0));
                end
            endcase
            s.last = (i == n - 1);
            pending_samples.push_back(s);
        end
    endtask

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Driver: present queued samples, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples.valid       <= 1'b0;
            samples.sample      <= '0;
            samples.last_sample <= 1'b0;
        end
        else if (!samples.valid || samples.ready)
        begin
            if (samples.valid)
            begin
                absorb_sample({samples.sample, samples.last_sample});
                sample_total++;
            end
            if (pending_samples.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                sample_item_t s;
                s = pending_samples.pop_front();
                samples.valid       <= 1'b1;
                samples.sample      <= s.value;
                samples.last_sample <= s.last;
            end
            else
            begin
                samples.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                stats_t got;
                stats_t exp_r;
                got = {results.mean_value, results.variance_value, results.smallest,
                       results.largest, results.sample_count, results.overflowed};
                if (expected_stats.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_stats.pop_front();
                    if (got.mean_value !== exp_r.mean_value)
                    begin
                        $display("%0t: mean expected %h actual %h", $time,
                                 exp_r.mean_value, got.mean_value);
                        error_count++;
                    end
                    if (got.variance_value !== exp_r.variance_value)
                    begin
                        $display("%0t: variance expected %h actual %h", $time,
                                 exp_r.variance_value, got.variance_value);
                        error_count++;
                    end
                    if (got.smallest !== exp_r.smallest)
                    begin
                        $display("%0t: min expected %h actual %h", $time,
                                 exp_r.smallest, got.smallest);
                        error_count++;
                    end
                    if (got.largest !== exp_r.largest)
                    begin
                        $display("%0t: max expected %h actual %h", $time,
                                 exp_r.largest, got.largest);
                        error_count++;
                    end
                    if (got.sample_count !== exp_r.sample_count)
                    begin
                        $display("%0t: count expected %0d actual %0d", $time,
                                 exp_r.sample_count, got.sample_count);
                        error_count++;
                    end
                    if (got.overflowed !== exp_r.overflowed)
                    begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 exp_r.overflowed, got.overflowed);
                        error_count++;
                    end
                end
            end
            results.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int n;
        error_count    = 0;
        run_count      = 0;
        sample_total   = 0;
        drop_runs      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clear_run_stats();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single samples at the extremes, tiny runs, memory full
        queue_run(1, MODE_FIXED, 32'h0000_0000);
        queue_run(1, MODE_FIXED, 32'hFFFF_FFFF);
        queue_run(2, MODE_EXTREME, 0);
        queue_run(3, MODE_EXTREME, 0);
        queue_run(4, MODE_FIXED, 32'hFFFF_FFFF);
        queue_run(5, MODE_FIXED, 32'hAAAA_AAAA);
        queue_run(5, MODE_FIXED, 32'h5555_5555);
        queue_run(3, MODE_RANDOM, 0);
        queue_run(smvmm_pkg::MAX_SAMPLES + 1, MODE_EXTREME, 0);

        // Random runs under each idling phase
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int k = 0; k < 10; k++)
            begin
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1)
                                                : $urandom_range(5, 1);
                queue_run(n, $urandom_range(MODE_EXTREME, MODE_RANDOM), $urandom);
            end
            while (pending_samples.size() > 0 || samples.valid) @(posedge clk);
        end

        fork
            begin
                while (expected_stats.size() > 0) @(posedge clk);
                repeat (400) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                $display("drain timeout, %0d results outstanding", expected_stats.size());
                error_count++;
            end
        join_any
        disable fork;

        $display("Covered %0d samples in %0d runs, %0d runs with dropped samples.",
                 sample_total, run_count, drop_runs);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/smvmm_pkg.sv
hw/rtl/smvmm_if.sv
hw/rtl/smvmm_div.sv
hw/rtl/smvmm_datapath.sv
hw/rtl/smvmm_ctrl.sv
hw/rtl/sample_mean_variance_min_max.sv
hw/rtl/smvmm_checker.sv
dv/testbench.sv
